[hdl/lsmd_pkg.sv]
// lsmd_pkg: shared types, constants and the cosine table of the lidar sector minimum block
// no dependencies; imported by every module under hdl
package lsmd_pkg;

    localparam int MAX_SAMPLES = 4096;
    localparam int MAX_HALF    = 64;
    localparam int COS_ENTRIES = 256;

    localparam int IDX_W   = $clog2(MAX_SAMPLES);
    localparam int N_W     = IDX_W + 1;
    localparam int OFF_W   = $clog2(MAX_HALF + 1);
    localparam int K_W     = $clog2(COS_ENTRIES + 1);
    localparam int KSH     = $clog2(COS_ENTRIES);
    localparam int RANGE_W = 16;
    localparam int STEP_W  = 16;
    localparam int HW_W    = 7;
    localparam int DIST_W  = 13;
    localparam int COS_W   = 16;

    // angle arithmetic, radians scaled by 65536 (HALF_PI_Q28 by 2^28)
    localparam int PI_Q16      = 205887;
    localparam int HALF_PI_Q16 = 102944;
    localparam int HALF_PI_Q28 = 421657428;
    localparam int ANGLE_W     = OFF_W + STEP_W;
    localparam int RED_W       = 18;
    localparam int FOLD_W      = 17;
    localparam int NUM_W       = FOLD_W + KSH + 1;
    // floor(2^32 / divisor); the estimate is low by at most one
    localparam int RECIP_PI      = 20860;
    localparam int RECIP_HALF_PI = 41721;
    localparam int RECIP_W       = 16;

    localparam logic [RANGE_W-1:0] NO_RETURN = '1;
    localparam logic [RANGE_W-1:0] MIN_CLEAR = '1;
    localparam int                 SAT_MM    = 5000;

    localparam int QUEUE_DEPTH = 4;

    // configuration register indexes (byte address = 4 * index)
    localparam int ADDR_W = 5;
    localparam logic [2:0] REG_HALF_WIDTH  = 3'd0;
    localparam logic [2:0] REG_ANGLE_STEP  = 3'd1;
    localparam logic [2:0] REG_SCAN_LENGTH = 3'd2;
    localparam logic [2:0] REG_FRONT_INDEX = 3'd3;
    localparam logic [2:0] REG_RIGHT_INDEX = 3'd4;
    localparam logic [2:0] REG_LEFT_INDEX  = 3'd5;

    typedef struct packed {
        logic [HW_W-1:0]   cone_half_width;
        logic [STEP_W-1:0] angle_step;
        logic [N_W-1:0]    scan_length;
        logic [IDX_W-1:0]  front_index;
        logic [IDX_W-1:0]  right_index;
        logic [IDX_W-1:0]  left_index;
    } cfg_t;

    typedef enum logic {
        JOB_TAKE,
        JOB_END
    } job_kind_t;

    typedef enum logic [1:0] {
        CONE_FRONT,
        CONE_RIGHT,
        CONE_BACK,
        CONE_LEFT
    } cone_t;

    typedef struct packed {
        job_kind_t          kind;
        cone_t              cone;
        logic [OFF_W-1:0]   offset;
        logic [RANGE_W-1:0] range_mm;
    } job_t;

    typedef struct packed {
        job_kind_t          kind;
        cone_t              cone;
        logic [RANGE_W-1:0] range_mm;
    } meta_t;

    typedef logic [COS_W-1:0] cos_rom_t [COS_ENTRIES+1];

    // cos(k * pi / (2 * COS_ENTRIES)) in Q1.15, Q28 taylor series, elaboration only
    function automatic logic [COS_W-1:0] cos_entry(input int unsigned k);
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic [63:0]        v;
        logic signed [63:0] sum;
        int                 n;
        x    = 64'(k) * 64'(HALF_PI_Q28) / 64'(COS_ENTRIES);
        x2   = (x * x) >> 28;
        term = 64'd1 << 28;
        sum  = $signed(term);
        for (n = 1; n <= 12; n++) begin
            term = ((term * x2) >> 28) / 64'((2 * n - 1) * (2 * n));
            if (n[0]) begin
                sum = sum - $signed(term);
            end else begin
                sum = sum + $signed(term);
            end
        end
        if (sum < 0) begin
            sum = 0;
        end
        v = ($unsigned(sum) + 64'd4096) >> 13;
        if (v > 64'd32768) begin
            v = 64'd32768;
        end
        return v[COS_W-1:0];
    endfunction

    function automatic cos_rom_t build_cos_rom();
        cos_rom_t r;
        for (int unsigned k = 0; k <= COS_ENTRIES; k++) begin
            r[k] = cos_entry(k);
        end
        return r;
    endfunction

    localparam cos_rom_t COS_ROM = build_cos_rom();

endpackage

[hdl/lsmd_front.sv]
// lsmd_front: accepts samples, tracks the scan index and splits each sample into cone jobs
// depends on lsmd_pkg; feeds lsmd_queue
module lsmd_front (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  lsmd_pkg::cfg_t                      cfg,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [lsmd_pkg::RANGE_W-1:0]        s_tdata,   // [15:0] range_mm
    input  logic                                s_tlast,   // last_sample
    output logic                                q_push,
    output lsmd_pkg::job_t                      q_job,
    input  logic                                q_full
);
    import lsmd_pkg::*;

    localparam int NUM_SLOT = 6;
    localparam int SLOT_W   = 3;
    localparam int D_W      = IDX_W + 2;
    localparam logic [SLOT_W-1:0] SLOT_FRONT   = 3'd0;
    localparam logic [SLOT_W-1:0] SLOT_RIGHT   = 3'd1;
    localparam logic [SLOT_W-1:0] SLOT_LEFT    = 3'd2;
    localparam logic [SLOT_W-1:0] SLOT_BACK_LO = 3'd3;
    localparam logic [SLOT_W-1:0] SLOT_BACK_HI = 3'd4;
    localparam logic [SLOT_W-1:0] SLOT_END     = 3'd5;

    logic [IDX_W-1:0]    idx_reg;
    logic                past_end_reg;
    logic [NUM_SLOT-1:0] pend_reg, pend_next, pend_after, hit;
    logic [RANGE_W-1:0]  range_reg;
    logic [OFF_W-1:0]    off_reg [5];
    logic [OFF_W-1:0]    off_new [5];

    logic [N_W-1:0]          n_eff, back_hi;
    logic [HW_W-1:0]         h_eff;
    logic                    active, accept;
    logic [IDX_W-1:0]        centre [3];
    logic signed [D_W-1:0]   d, mag, h_s;
    logic [SLOT_W-1:0]       sel;

    assign n_eff = (cfg.scan_length > N_W'(MAX_SAMPLES)) ? N_W'(MAX_SAMPLES) : cfg.scan_length;
    assign h_eff = (cfg.cone_half_width > HW_W'(MAX_HALF)) ? HW_W'(MAX_HALF)
                                                           : cfg.cone_half_width;
    assign active = !past_end_reg && (N_W'(idx_reg) < n_eff) && (s_tdata != NO_RETURN);

    assign centre[0] = cfg.front_index;
    assign centre[1] = cfg.right_index;
    assign centre[2] = cfg.left_index;
    assign h_s       = $signed(D_W'(h_eff));
    assign back_hi   = n_eff - N_W'(1) - N_W'(idx_reg);

    // window tests for the three centred cones and both ends of the back cone; the end slot follows s_tlast
    always_comb begin
        hit = '0;
        d   = '0;
        mag = '0;
        for (int i = 0; i < 3; i++) begin
            d          = $signed(D_W'(idx_reg)) - $signed(D_W'(centre[i]));
            mag        = (d < 0) ? -d : d;
            hit[i]     = active && (d >= -h_s) && (d < h_s);
            off_new[i] = mag[OFF_W-1:0];
        end
        hit[SLOT_BACK_LO]     = active && (N_W'(idx_reg) < N_W'(h_eff));
        off_new[SLOT_BACK_LO] = idx_reg[OFF_W-1:0];
        hit[SLOT_BACK_HI]     = active && ((D_W'(idx_reg) + D_W'(h_eff)) >= D_W'(n_eff));
        off_new[SLOT_BACK_HI] = back_hi[OFF_W-1:0];
        hit[SLOT_END]         = s_tlast;
    end

    // lowest pending slot goes out first, end marker last
    always_comb begin
        sel = SLOT_END;
        for (int i = NUM_SLOT - 1; i >= 0; i--) begin
            if (pend_reg[i]) begin
                sel = SLOT_W'(i);
            end
        end
    end

    assign q_push     = (pend_reg != '0) && !q_full;
    assign pend_after = q_push ? (pend_reg & ~(NUM_SLOT'(1) << sel)) : pend_reg;
    assign s_tready   = (pend_after == '0);
    assign accept     = s_tvalid && s_tready;
    assign pend_next  = accept ? hit : pend_after;

    always_comb begin
        q_job.kind     = JOB_TAKE;
        q_job.range_mm = range_reg;
        q_job.cone     = CONE_FRONT;
        q_job.offset   = '0;
        case (sel)
            SLOT_FRONT: begin
                q_job.offset = off_reg[0];
            end
            SLOT_RIGHT: begin
                q_job.cone   = CONE_RIGHT;
                q_job.offset = off_reg[1];
            end
            SLOT_LEFT: begin
                q_job.cone   = CONE_LEFT;
                q_job.offset = off_reg[2];
            end
            SLOT_BACK_LO: begin
                q_job.cone   = CONE_BACK;
                q_job.offset = off_reg[3];
            end
            SLOT_BACK_HI: begin
                q_job.cone   = CONE_BACK;
                q_job.offset = off_reg[4];
            end
            default: begin
                q_job.kind = JOB_END;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg     <= '0;
            idx_reg      <= '0;
            past_end_reg <= 1'b0;
        end else begin
            pend_reg <= pend_next;
            if (accept) begin
                if (s_tlast) begin
                    idx_reg      <= '0;
                    past_end_reg <= 1'b0;
                end else if (idx_reg == IDX_W'(MAX_SAMPLES - 1)) begin
                    past_end_reg <= 1'b1;
                end else begin
                    idx_reg <= idx_reg + IDX_W'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            range_reg <= s_tdata;
            off_reg   <= off_new;
        end
    end

    // index stops at its top value once the scan has overrun
    a_past_end_idx: assert property (@(posedge aclk) disable iff (!aresetn)
        past_end_reg |-> idx_reg == IDX_W'(MAX_SAMPLES - 1))
        else $error("past_end set with index below top");

endmodule

[hdl/lsmd_queue.sv]
// lsmd_queue: short flop-based job queue between the front and back parts
// depends on lsmd_pkg
module lsmd_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  lsmd_pkg::job_t push_job,
    output logic           full,
    input  logic           pop,
    output lsmd_pkg::job_t head_job,
    output logic           empty
);
    import lsmd_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    job_t             mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full     = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign head_job = mem_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("job queue overflow");

    a_fill_matches_ptrs: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg != CNT_W'(QUEUE_DEPTH)) |-> (PTR_W'(count_reg) == wr_ptr_reg - rd_ptr_reg))
        else $error("queue count out of step with pointers");

endmodule

[hdl/lsmd_back.sv]
// lsmd_back: projection pipeline (angle reduce, cosine lookup, multiply), cone minima, result
// depends on lsmd_pkg; drains lsmd_queue
module lsmd_back (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic [lsmd_pkg::STEP_W-1:0] angle_step,
    input  lsmd_pkg::job_t              q_job,
    input  logic                        q_empty,
    output logic                        q_pop,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [55:0]                 m_tdata    // [12:0] front_mm, [25:13] right_mm,
                                                   // [38:26] back_mm, [51:39] left_mm
);
    import lsmd_pkg::*;

    localparam int P1_W = ANGLE_W + RECIP_W;
    localparam int P2_W = NUM_W + RECIP_W;
    localparam int Q1_W = P1_W - 32;

    logic adv;
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg, v7_reg, v8_reg, v9_reg;
    meta_t m1_reg, m2_reg, m3_reg, m4_reg, m5_reg, m6_reg, m7_reg, m8_reg, m9_reg;

    logic [ANGLE_W-1:0]   angle1_reg, angle2_reg;
    logic [Q1_W-1:0]      q1_reg;
    logic [RED_W:0]       r3_reg;
    logic [RED_W-1:0]     red4_reg;
    logic [NUM_W-1:0]     num5_reg, num6_reg;
    logic [K_W-1:0]       q6_reg, k7_reg;
    logic [COS_W-1:0]     c8_reg;
    logic [RANGE_W-1:0]   dist9_reg;

    logic [P1_W-1:0]      prod1;
    logic [ANGLE_W-1:0]   qpi, diff3;
    logic [RED_W-1:0]     red_next;
    logic [FOLD_W-1:0]    fold;
    logic [P2_W-1:0]      prod2;
    logic [NUM_W-1:0]     qhp, rem7;
    logic [K_W-1:0]       k_next;
    logic [31:0]          prod9;

    logic [RANGE_W-1:0]   min_reg [4];
    logic                 m_tvalid_reg;
    logic [55:0]          m_tdata_reg;
    logic                 end_fire;

    function automatic logic [DIST_W-1:0] sat(input logic [RANGE_W-1:0] v);
        return (v > RANGE_W'(SAT_MM)) ? DIST_W'(SAT_MM) : v[DIST_W-1:0];
    endfunction

    // an end job waits in the last stage while the result register is full and not taken
    assign end_fire = v9_reg && (m9_reg.kind == JOB_END);
    assign adv      = !(end_fire && m_tvalid_reg && !m_tready);
    assign q_pop    = adv && !q_empty;

    // quotient estimates by reciprocal (q1_reg, q6_reg), corrected by a remainder compare (red_next, k_next)
    assign prod1    = P1_W'(angle1_reg) * P1_W'(RECIP_PI);
    assign qpi      = ANGLE_W'(q1_reg) * ANGLE_W'(PI_Q16);
    assign diff3    = angle2_reg - qpi;
    assign red_next = (r3_reg >= (RED_W+1)'(PI_Q16)) ? RED_W'(r3_reg - (RED_W+1)'(PI_Q16))
                                                     : r3_reg[RED_W-1:0];
    // fold about pi/2, then scale to a table index with rounding
    assign fold     = (red4_reg > RED_W'(HALF_PI_Q16))
                    ? FOLD_W'(RED_W'(PI_Q16) - red4_reg) : red4_reg[FOLD_W-1:0];
    assign prod2    = P2_W'(num5_reg) * P2_W'(RECIP_HALF_PI);
    assign qhp      = NUM_W'(q6_reg) * NUM_W'(HALF_PI_Q16);
    assign rem7     = num6_reg - qhp;
    always_comb begin
        k_next = q6_reg;
        if (rem7 >= NUM_W'(HALF_PI_Q16)) begin
            k_next = q6_reg + K_W'(1);
        end
        if (k_next > K_W'(COS_ENTRIES)) begin
            k_next = K_W'(COS_ENTRIES);
        end
    end
    assign prod9 = 32'(m8_reg.range_mm) * 32'(c8_reg) + 32'd16384;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            {v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg, v7_reg, v8_reg, v9_reg} <= '0;
        end else if (adv) begin
            {v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg, v7_reg, v8_reg, v9_reg} <=
                {q_pop, v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg, v7_reg, v8_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m1_reg     <= '{kind: q_job.kind, cone: q_job.cone, range_mm: q_job.range_mm};
            angle1_reg <= ANGLE_W'(q_job.offset) * ANGLE_W'(angle_step);
            m2_reg     <= m1_reg;
            angle2_reg <= angle1_reg;
            q1_reg     <= prod1[P1_W-1:32];
            m3_reg     <= m2_reg;
            r3_reg     <= diff3[RED_W:0];
            m4_reg     <= m3_reg;
            red4_reg   <= red_next;
            m5_reg     <= m4_reg;
            num5_reg   <= (NUM_W'(fold) << KSH) + NUM_W'(HALF_PI_Q16 / 2);
            m6_reg     <= m5_reg;
            num6_reg   <= num5_reg;
            q6_reg     <= K_W'(prod2[P2_W-1:32]);
            m7_reg     <= m6_reg;
            k7_reg     <= k_next;
            m8_reg     <= m7_reg;
            c8_reg     <= COS_ROM[k7_reg];
            m9_reg     <= m8_reg;
            dist9_reg  <= prod9[RANGE_W+14:15];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 4; i++) begin
                min_reg[i] <= MIN_CLEAR;
            end
            m_tvalid_reg <= 1'b0;
        end else begin
            if (adv && end_fire) begin
                m_tvalid_reg <= 1'b1;
                for (int i = 0; i < 4; i++) begin
                    min_reg[i] <= MIN_CLEAR;
                end
            end else begin
                if (m_tready) begin
                    m_tvalid_reg <= 1'b0;
                end
                if (adv && v9_reg && (dist9_reg < min_reg[m9_reg.cone])) begin
                    min_reg[m9_reg.cone] <= dist9_reg;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv && end_fire) begin
            m_tdata_reg <= {4'b0, sat(min_reg[CONE_LEFT]), sat(min_reg[CONE_BACK]),
                            sat(min_reg[CONE_RIGHT]), sat(min_reg[CONE_FRONT])};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    a_end_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (adv && end_fire) |=> (min_reg[CONE_FRONT] == MIN_CLEAR)
            && (min_reg[CONE_RIGHT] == MIN_CLEAR) && (min_reg[CONE_BACK] == MIN_CLEAR)
            && (min_reg[CONE_LEFT] == MIN_CLEAR))
        else $error("minima not cleared after result");

    a_stall_holds_end: assert property (@(posedge aclk) disable iff (!aresetn)
        !adv |=> end_fire && m_tvalid_reg)
        else $error("end job lost while result stalled");

endmodule

[hdl/lidar_sector_min_distance_top.sv]
// lidar_sector_min_distance_top: register port and wiring of front, queue and back parts
// depends on lsmd_pkg, lsmd_front, lsmd_queue, lsmd_back
//
// Input stream: one lidar sample per word, range_mm in s_tdata[15:0], s_tlast marks the
// final sample of a scan. Samples are counted from zero after reset and after each last.
// Output stream: one word per scan, issued for the sample marked last, holding the four
// cone minima (front, right, back, left) each saturated at 5000 mm.
// The front part takes a sample and emits one job per cone window the sample falls in,
// plus an end job on the last sample; it takes the next sample in the same cycle its
// final job leaves, while a full queue holds the jobs back.
// Jobs pass a 4-deep queue into a 9-stage projection pipeline (angle reduce, cosine table,
// multiply) that retires one job per cycle unless a stalled result holds it.
// Configuration must be written over the register port only while the block is idle;
// the block itself does not enforce this.
// Reset (aresetn low, synchronous) restores register defaults, clears the minima and the
// sample count, and empties the queue and the pipeline.
// A stalled result holds the pipeline once the next end job reaches its last stage; the
// queue then fills and s_tready drops.
module lidar_sector_min_distance_top (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [lsmd_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [15:0]                 s_tdata,   // [15:0] range_mm
    input  logic                        s_tlast,   // last_sample
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [55:0]                 m_tdata    // [12:0] front_mm, [25:13] right_mm,
                                                   // [38:26] back_mm, [51:39] left_mm
);
    import lsmd_pkg::*;

    cfg_t       cfg_reg;
    logic       wr_en;
    logic [2:0] reg_sel;
    logic       q_push, q_full, q_pop, q_empty;
    job_t       push_job, head_job;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_sel = paddr[ADDR_W-1:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.cone_half_width <= HW_W'(20);
            cfg_reg.angle_step      <= STEP_W'(1144);
            cfg_reg.scan_length     <= N_W'(360);
            cfg_reg.front_index     <= IDX_W'(180);
            cfg_reg.right_index     <= IDX_W'(90);
            cfg_reg.left_index      <= IDX_W'(270);
        end else if (wr_en) begin
            case (reg_sel)
                REG_HALF_WIDTH:  cfg_reg.cone_half_width <= pwdata[HW_W-1:0];
                REG_ANGLE_STEP:  cfg_reg.angle_step      <= pwdata[STEP_W-1:0];
                REG_SCAN_LENGTH: cfg_reg.scan_length     <= pwdata[N_W-1:0];
                REG_FRONT_INDEX: cfg_reg.front_index     <= pwdata[IDX_W-1:0];
                REG_RIGHT_INDEX: cfg_reg.right_index     <= pwdata[IDX_W-1:0];
                REG_LEFT_INDEX:  cfg_reg.left_index      <= pwdata[IDX_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_sel)
            REG_HALF_WIDTH:  prdata = 32'(cfg_reg.cone_half_width);
            REG_ANGLE_STEP:  prdata = 32'(cfg_reg.angle_step);
            REG_SCAN_LENGTH: prdata = 32'(cfg_reg.scan_length);
            REG_FRONT_INDEX: prdata = 32'(cfg_reg.front_index);
            REG_RIGHT_INDEX: prdata = 32'(cfg_reg.right_index);
            REG_LEFT_INDEX:  prdata = 32'(cfg_reg.left_index);
            default:         prdata = '0;
        endcase
    end

    lsmd_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_push   (q_push),
        .q_job    (push_job),
        .q_full   (q_full)
    );

    lsmd_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_job (push_job),
        .full     (q_full),
        .pop      (q_pop),
        .head_job (head_job),
        .empty    (q_empty)
    );

    lsmd_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .angle_step (cfg_reg.angle_step),
        .q_job      (head_job),
        .q_empty    (q_empty),
        .q_pop      (q_pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

endmodule
